// ----- sv/scwa_pkg.sv -----
// Package for the sigma-clipped window average block.
// Holds field widths, default constants and the sequencer state type.
// No dependencies.
package scwa_pkg;

   localparam int WINDOW_DEFAULT = 8;
   localparam int SAMPLE_W       = 16;
   localparam int GAIN_W         = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int VELOCITY_W     = 20;
   localparam int KEPT_W         = 7;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd17461;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE_PASS,
      ST_CLIP_PASS,
      ST_DIVIDE,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

endpackage

// ----- sv/scwa_mem.sv -----
// Single-port-write, single-port-read window store with registered read data.
// Used by the sigma-clipped window average top level; no package dependency.
module scwa_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/scwa_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the sigma-clipped window average top level; no package dependency.
module scwa_div #(
   parameter int DIVIDEND_W = 19,
   parameter int DIVISOR_W  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial     = rem_shift - {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff - 1'b1;
         if (!trial[DIVISOR_W]) begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/sigma_clipped_window_average.sv -----
// Sigma-clipped window average: top level with sequencer and shared multiplier.
// Depends on scwa_pkg, scwa_mem and scwa_div.
//
// Usage: samples (unsigned Q8.8) arrive on the req_ channel by valid/ready.
// A zero sample is accepted and discarded. Nonzero samples fill a window of
// WINDOW entries, one transaction per cycle while req_ready is high. The
// transaction that fills the window starts the computation and req_ready
// falls until the result has been placed in the output register.
// The computation walks the window twice through one shared multiplier
// (squared deviations, then the one-sigma test), runs a one-bit-per-cycle
// divider for the average and reuses the multiplier for the gain.
// The result waits in the rsp_ output register; the block goes back to
// accepting samples once it has been loaded, so a stalled receiver only
// holds up the next full window. The gain is written through csr_wr_en and
// csr_wr_data only while the block is idle: a rule for the user, which the
// block itself does not enforce. Reset is synchronous: it empties the
// window, restores the default gain and drops rsp_valid.
module sigma_clipped_window_average #(
   parameter int WINDOW = scwa_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [scwa_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [scwa_pkg::VELOCITY_W-1:0] rsp_velocity,
   output logic [scwa_pkg::KEPT_W-1:0]     rsp_kept_count,
   input  logic                            csr_wr_en,
   input  logic [scwa_pkg::GAIN_W-1:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = scwa_pkg::SAMPLE_W + IDX_W;
   localparam int SQ_W  = 2 * SUM_W;
   localparam int TOT_W = SQ_W + IDX_W;
   localparam int SW    = scwa_pkg::SAMPLE_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] WIN_C    = CNT_W'(WINDOW);
   localparam logic [SUM_W-1:0] WIN_S    = SUM_W'(WINDOW);
   localparam logic [TOT_W-1:0] WIN_T    = TOT_W'(WINDOW);

   scwa_pkg::state_type state_ff, state_in;

   logic [scwa_pkg::GAIN_W-1:0] gain_ff;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rd_valid_ff, v2_ff, v3_ff;
   logic [SUM_W-1:0]  dev_ff, dev_in;
   logic [SW-1:0]     x2_ff, x3_ff;
   logic [SQ_W-1:0]   prod_ff;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  kept_sum_ff, kept_sum_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [scwa_pkg::VELOCITY_W-1:0] velocity_ff;
   logic [scwa_pkg::KEPT_W-1:0]     kept_count_ff;

   logic              accept, take, last;
   logic              in_pass, issuing, pass_done, scale_sel, out_load;
   logic              keep;
   logic [SW-1:0]     rd_data;
   logic [SUM_W:0]    diff;
   logic [SUM_W-1:0]  mul_a, mul_b;
   logic [SQ_W-1:0]   mul_p;
   logic              div_start, div_done;
   logic [SUM_W-1:0]  quotient;

   scwa_mem #(
      .DEPTH  (WINDOW),
      .ADDR_W (IDX_W),
      .DATA_W (SW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (fill_ff),
      .wr_data (req_sample),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   scwa_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (kept_sum_ff),
      .divisor  (kept_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Control decode.
   always_comb begin
      req_ready = 1'b0;
      in_pass   = 1'b0;
      scale_sel = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         scwa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         scwa_pkg::ST_SQUARE_PASS, scwa_pkg::ST_CLIP_PASS: begin
            in_pass = 1'b1;
         end
         scwa_pkg::ST_DIVIDE: begin
         end
         scwa_pkg::ST_SCALE: begin
            scale_sel = 1'b1;
         end
         scwa_pkg::ST_OUTPUT: begin
            scale_sel = 1'b1;
            out_load  = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign take      = accept && (req_sample != '0);
   assign last      = take && (fill_ff == LAST_IDX);
   assign issuing   = in_pass && (issue_ff != WIN_C);
   assign pass_done = in_pass && (issue_ff == WIN_C) && !rd_valid_ff && !v2_ff && !v3_ff;
   assign div_start = (state_ff == scwa_pkg::ST_CLIP_PASS) && pass_done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scwa_pkg::ST_IDLE:        if (last) state_in = scwa_pkg::ST_SQUARE_PASS;
         scwa_pkg::ST_SQUARE_PASS: if (pass_done) state_in = scwa_pkg::ST_CLIP_PASS;
         scwa_pkg::ST_CLIP_PASS:   if (pass_done) state_in = scwa_pkg::ST_DIVIDE;
         scwa_pkg::ST_DIVIDE:      if (div_done) state_in = scwa_pkg::ST_SCALE;
         scwa_pkg::ST_SCALE:       state_in = scwa_pkg::ST_OUTPUT;
         scwa_pkg::ST_OUTPUT:      if (out_load) state_in = scwa_pkg::ST_IDLE;
         default:                  state_in = scwa_pkg::ST_IDLE;
      endcase
   end

   // Shared multiplier: squares deviations during the passes, applies the gain at the end.
   always_comb begin
      mul_a = scale_sel ? quotient : dev_ff;
      mul_b = scale_sel ? SUM_W'(gain_ff) : dev_ff;
      mul_p = SQ_W'(mul_a) * SQ_W'(mul_b);
   end

   always_comb begin
      diff   = {1'b0, SUM_W'(rd_data) * WIN_S} - {1'b0, sum_ff};
      dev_in = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
      keep   = (TOT_W'(prod_ff) * WIN_T) <= total_ff;
   end

   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (take) begin
         fill_in = last ? '0 : fill_ff + 1'b1;
         sum_in  = sum_ff + SUM_W'(req_sample);
      end else if (div_start) begin
         sum_in = '0;
      end

      issue_in = issue_ff;
      if (pass_done) begin
         issue_in = '0;
      end else if (issuing) begin
         issue_in = issue_ff + 1'b1;
      end

      total_in = total_ff;
      if (last) begin
         total_in = '0;
      end else if ((state_ff == scwa_pkg::ST_SQUARE_PASS) && v3_ff) begin
         total_in = total_ff + TOT_W'(prod_ff);
      end

      kept_sum_in = kept_sum_ff;
      kept_in     = kept_ff;
      if ((state_ff == scwa_pkg::ST_SQUARE_PASS) && pass_done) begin
         kept_sum_in = '0;
         kept_in     = '0;
      end else if ((state_ff == scwa_pkg::ST_CLIP_PASS) && v3_ff && keep) begin
         kept_sum_in = kept_sum_ff + SUM_W'(x3_ff);
         kept_in     = kept_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scwa_pkg::ST_IDLE;
         gain_ff      <= scwa_pkg::GAIN_RESET;
         fill_ff      <= '0;
         sum_ff       <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= issuing;
         v2_ff        <= rd_valid_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff      <= dev_in;
      x2_ff       <= rd_data;
      x3_ff       <= x2_ff;
      prod_ff     <= mul_p;
      total_ff    <= total_in;
      kept_sum_ff <= kept_sum_in;
      kept_ff     <= kept_in;
      if (out_load) begin
         velocity_ff   <= prod_ff[scwa_pkg::GAIN_FRAC +: scwa_pkg::VELOCITY_W];
         kept_count_ff <= scwa_pkg::KEPT_W'(kept_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_velocity   = velocity_ff;
   assign rsp_kept_count = kept_count_ff;

endmodule

// ----- tb/sigma_clipped_window_average_tb.sv -----
// Self-checking testbench for sigma_clipped_window_average: drives samples and gain
// writes, and checks every result against a scoreboard that does its own clipped averaging.
// Depends on scwa_pkg and the sigma_clipped_window_average RTL.
module sigma_clipped_window_average_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW        = scwa_pkg::WINDOW_DEFAULT;
   localparam int SAMPLE_W      = scwa_pkg::SAMPLE_W;
   localparam int GAIN_W        = scwa_pkg::GAIN_W;
   localparam int VELOCITY_W    = scwa_pkg::VELOCITY_W;
   localparam int KEPT_W        = scwa_pkg::KEPT_W;
   localparam int PHASE_ITEMS   = 160;
   localparam int SETTLE_CYCLES = 2 * (WINDOW + 4) + 16 + $clog2(WINDOW) + 3 + 16;
   localparam int IDLE_LIMIT    = 4000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic [VELOCITY_W-1:0] velocity;
      logic [KEPT_W-1:0]     kept_count;
   } velocity_result_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   class velocity_scoreboard_type;
      logic [GAIN_W-1:0]   gain;
      logic [SAMPLE_W-1:0] window_store[WINDOW];
      int                  fill;
      logic [21:0]         window_total;
      velocity_result_type expected_velocities[$];
      int                  errors;
      int                  samples;
      int                  blanks;
      int                  checked;

      function new();
         gain = scwa_pkg::GAIN_RESET;
         fill = 0;
         window_total = '0;
         errors = 0;
         samples = 0;
         blanks = 0;
         checked = 0;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] x);
         longint              dev[WINDOW];
         longint unsigned     spread_total;
         longint unsigned     sq;
         longint unsigned     kept_sum;
         longint unsigned     avg;
         longint unsigned     scaled;
         int                  kept;
         velocity_result_type want;
         samples++;
         if (x == '0) begin
            blanks++;
            return;
         end
         window_store[fill] = x;
         window_total = window_total + 22'(x);
         fill++;
         if (fill < WINDOW) return;
         spread_total = 0;
         for (int i = 0; i < WINDOW; i++) begin
            dev[i] = longint'(WINDOW) * longint'(window_store[i]) - longint'(window_total);
            spread_total += longint'(dev[i] * dev[i]);
         end
         kept_sum = 0;
         kept = 0;
         for (int i = 0; i < WINDOW; i++) begin
            sq = longint'(dev[i] * dev[i]);
            if (sq * WINDOW <= spread_total) begin
               kept_sum += window_store[i];
               kept++;
            end
         end
         avg = (kept != 0) ? kept_sum / kept : 0;
         scaled = (avg * longint'(gain)) >> scwa_pkg::GAIN_FRAC;
         want.velocity = scaled[VELOCITY_W-1:0];
         want.kept_count = kept[KEPT_W-1:0];
         expected_velocities.push_back(want);
         fill = 0;
         window_total = '0;
      endfunction

      function void check_velocity(logic [VELOCITY_W-1:0] velocity,
                                   logic [KEPT_W-1:0] kept_count);
         velocity_result_type want;
         if (expected_velocities.size() == 0) begin
            $display("%0t: unexpected result, velocity %0d kept_count %0d", $time,
                     velocity, kept_count);
            errors++;
            return;
         end
         want = expected_velocities.pop_front();
         checked++;
         if (velocity !== want.velocity) begin
            $display("%0t: velocity mismatch, expected %0d, actual %0d", $time,
                     want.velocity, velocity);
            errors++;
         end
         if (kept_count !== want.kept_count) begin
            $display("%0t: kept_count mismatch, expected %0d, actual %0d", $time,
                     want.kept_count, kept_count);
            errors++;
         end
      endfunction

      function int pending();
         return expected_velocities.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VELOCITY_W-1:0] rsp_velocity;
   logic [KEPT_W-1:0]     rsp_kept_count;
   logic                  csr_wr_en = 1'b0;
   logic [GAIN_W-1:0]     csr_wr_data = '0;

   velocity_scoreboard_type sb = new();
   int          burst_left = 0;
   int          centre = 1000;
   int          noise = 4;
   int          gain_settings = 1;
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_left = 0;
   int          rx_tick = 0;
   int          idle_cycles = 0;

   sigma_clipped_window_average #(.WINDOW(WINDOW)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_velocity   (rsp_velocity),
      .rsp_kept_count (rsp_kept_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic send_sample(input logic [SAMPLE_W-1:0] x);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(x);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] g);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.gain = g;
      gain_settings++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 15))
         0, 1: return '0;
         2: return SAMPLE_W'($urandom_range(1, 65535));
         3: return SAMPLE_W'(centre);
         4: return (centre > 32768) ? SAMPLE_W'(1) : SAMPLE_MAX;
         default: begin
            v = centre + int'($urandom_range(0, 2 * noise)) - noise;
            if (v < 1) v = 1;
            if (v > 65535) v = 65535;
            return SAMPLE_W'(v);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_velocity(rsp_velocity, rsp_kept_count);
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(32, 256);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_ALWAYS: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= (rx_tick % 8 == 0);
         default:   rsp_ready <= (rx_tick % 4 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [SAMPLE_W-1:0] directed[25];
      logic [GAIN_W-1:0]   gains[6];
      directed = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF,
                   16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                   16'hFFFF,
                   16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                   16'hFFFF};
      gains = '{16'hFFFF, 16'h0000, 16'h1000, 16'h0001, 16'h0000, 16'h0000};
      gains[4] = GAIN_W'($urandom_range(0, 65535));
      gains[5] = GAIN_W'($urandom_range(0, 65535));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default gain: all-equal window, exact one-sigma split and a single outlier.
      foreach (directed[i]) send_sample(directed[i]);

      foreach (gains[p]) begin
         write_gain(gains[p]);
         repeat (WINDOW) send_sample(SAMPLE_MAX);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain();
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 2))
                  0: centre = $urandom_range(1, 64);
                  1: centre = $urandom_range(1, 65535);
                  default: centre = $urandom_range(65000, 65535);
               endcase
               noise = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
                                                   : $urandom_range(0, 2000);
            end
            send_sample(pick_sample());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d samples (%0d blank) under %0d gain settings;",
               sb.samples, sb.blanks, gain_settings);
      $display("%0d window results were checked, %0d errors found.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
